@@ sv/srcc_pkg.sv @@
// Shared types and constants for the swept rectangle collision clamp.
`default_nettype none
package srcc_pkg;
   localparam int CW = 16;   // coordinate width at the ports
   localparam int SW = 15;   // size register width
   localparam int W  = 20;   // internal exact arithmetic width

   localparam logic [2:0] KIND_CLEAR   = 3'd0;
   localparam logic [2:0] KIND_ADD     = 3'd1;
   localparam logic [2:0] KIND_MOVE    = 3'd2;
   localparam logic [2:0] KIND_OVERLAP = 3'd3;
   localparam logic [2:0] KIND_RESIZE  = 3'd4;

   localparam logic CSR_MIN_SIZE = 1'b0;
   localparam logic CSR_MAX_SIZE = 1'b1;

   typedef struct packed {
      logic [2:0]           kind;
      logic signed [CW-1:0] coord_a;
      logic signed [CW-1:0] coord_b;
      logic signed [CW-1:0] coord_c;
      logic signed [CW-1:0] coord_d;
      logic signed [CW-1:0] target_a;
      logic signed [CW-1:0] target_b;
      logic                 flip_x;
      logic                 flip_y;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] result_a;
      logic signed [CW-1:0] result_b;
      logic                 hit;
      logic                 table_full;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture transaction, apply clear/add
      logic setup1;   // build first sweep rectangle
      logic setup2;   // build second sweep rectangle
      logic rd_en;    // read one obstacle
      logic finish;   // form and present result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_p1;
      logic need_p2;
   } stat_type;
endpackage
`default_nettype wire

@@ sv/srcc_ctrl.sv @@
// Sequencer for table passes of the collision clamp.
`default_nettype none
module srcc_ctrl #(
   parameter int IW = 8,
   parameter int NW = 9
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [NW-1:0]      count,
   input  wire srcc_pkg::stat_type stat,
   output srcc_pkg::cmd_type       cmd,
   output logic [IW-1:0]           rd_addr,
   output logic                    busy
);
   import srcc_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_SETUP1 = 8'b00000010,
      ST_RUN1   = 8'b00000100,
      ST_DRAIN1 = 8'b00001000,
      ST_SETUP2 = 8'b00010000,
      ST_RUN2   = 8'b00100000,
      ST_DRAIN2 = 8'b01000000,
      ST_DONE   = 8'b10000000
   } state_type;

   state_type     state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          last;
   logic          empty;

   assign empty   = (count == '0);
   assign last    = ({{(NW-IW){1'b0}}, idx_ff} == (count - NW'(1)));
   assign rd_addr = idx_ff;
   assign busy    = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP1;
            end
         end
         ST_SETUP1: begin
            cmd.setup1 = 1'b1;
            idx_in     = '0;
            state_in   = (stat.need_p1 && !empty) ? ST_RUN1 : ST_SETUP2;
         end
         ST_RUN1, ST_RUN2: begin
            cmd.rd_en = 1'b1;
            if (last) begin
               // the drain state lets the last entry be evaluated
               state_in = (state_ff == ST_RUN1) ? ST_DRAIN1 : ST_DRAIN2;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_DRAIN1: begin
            state_in = ST_SETUP2;
         end
         ST_SETUP2: begin
            cmd.setup2 = 1'b1;
            idx_in     = '0;
            state_in   = (stat.need_p2 && !empty) ? ST_RUN2 : ST_DONE;
         end
         ST_DRAIN2: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end
endmodule
`default_nettype wire

@@ sv/srcc_dp.sv @@
// Obstacle memory, sweep rectangles and nearest-edge evaluation.
`default_nettype none
module srcc_dp #(
   parameter int DEPTH = 256,
   parameter int IW    = 8,
   parameter int NW    = 9
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire srcc_pkg::req_type      req_data,
   input  wire srcc_pkg::cmd_type      cmd,
   input  wire logic [IW-1:0]          rd_addr,
   input  wire logic                   csr_we,
   input  wire logic                   csr_idx,
   input  wire logic [srcc_pkg::SW-1:0] csr_wdata,
   output logic [NW-1:0]               count,
   output srcc_pkg::stat_type          stat,
   output logic                        rsp_valid,
   output srcc_pkg::rsp_type           rsp_data
);
   import srcc_pkg::*;

   logic [4*CW-1:0] mem [DEPTH];
   logic [4*CW-1:0] rd_data_ff;
   logic            ev_ff;
   logic            pass2_ff;

   logic [NW-1:0]   count_ff;
   logic [SW-1:0]   min_ff, max_ff;
   logic            full_ff;
   logic [2:0]      kind_ff;
   logic signed [W-1:0] a_ff, b_ff, c_ff, d_ff, ta_ff, tb_ff;
   logic            fx_ff, fy_ff;
   logic signed [W-1:0] sl_ff, st_ff, sr_ff, sb_ff;
   logic signed [W-1:0] ux_ff, uy_ff, wv_ff, hv_ff, best_ff;
   logic            found_ff, hit_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff, rsp_in;

   logic signed [W-1:0] w, h, ol, ot, orr, ob, cand, gap, eff_w, left;
   logic            ov, grow_w, grow_h;

   function automatic logic signed [W-1:0] sx(input logic [CW-1:0] v);
      return {{(W-CW){v[CW-1]}}, v};
   endfunction

   function automatic logic signed [W-1:0] smin(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
      return (x < y) ? x : y;
   endfunction

   function automatic logic signed [W-1:0] smax(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
      return (x > y) ? x : y;
   endfunction

   function automatic logic [CW-1:0] sat(input logic signed [W-1:0] v);
      if (v < -W'(32768)) return 16'h8000;
      if (v > W'(32767))  return 16'h7fff;
      return v[CW-1:0];
   endfunction

   function automatic logic [CW-1:0] clampsz(input logic signed [W-1:0] v,
                                              input logic [SW-1:0] lo,
                                              input logic [SW-1:0] hi);
      logic signed [W-1:0] t;
      t = v;
      if (t < $signed({{(W-SW){1'b0}}, lo})) t = $signed({{(W-SW){1'b0}}, lo});
      if (t > $signed({{(W-SW){1'b0}}, hi})) t = $signed({{(W-SW){1'b0}}, hi});
      return t[CW-1:0];
   endfunction

   assign w      = c_ff - a_ff;
   assign h      = d_ff - b_ff;
   assign grow_w = ta_ff > c_ff;
   assign grow_h = tb_ff > d_ff;
   assign eff_w  = grow_w ? wv_ff : c_ff;
   assign left   = fx_ff ? (a_ff - eff_w) : a_ff;

   assign ol  = sx(rd_data_ff[4*CW-1:3*CW]);
   assign ot  = sx(rd_data_ff[3*CW-1:2*CW]);
   assign orr = sx(rd_data_ff[2*CW-1:CW]);
   assign ob  = sx(rd_data_ff[CW-1:0]);
   assign ov  = (sl_ff < orr) && (ol < sr_ff) && (st_ff < ob) && (ot < sb_ff);

   // candidate edge and its distance for the active pass
   always_comb begin
      cand = '0;
      if (kind_ff == KIND_MOVE) begin
         if (!pass2_ff) cand = (ta_ff > a_ff) ? (ol - w) : orr;
         else           cand = (tb_ff > b_ff) ? (ot - h) : ob;
      end else begin
         if (!pass2_ff) cand = fx_ff ? (a_ff - orr) : (ol - a_ff);
         else           cand = fy_ff ? (b_ff - ob) : (ot - b_ff);
      end
   end
   always_comb begin
      gap = cand - (pass2_ff ? b_ff : a_ff);
      if (gap < 0) gap = -gap;
   end

   always_comb begin
      rsp_in            = '0;
      rsp_in.table_full = full_ff;
      if (kind_ff == KIND_MOVE) begin
         rsp_in.result_a = sat(ux_ff);
         rsp_in.result_b = sat(uy_ff);
         rsp_in.hit      = hit_ff;
      end else if (kind_ff == KIND_RESIZE) begin
         rsp_in.result_a = clampsz(wv_ff, min_ff, max_ff);
         rsp_in.result_b = clampsz(hv_ff, min_ff, max_ff);
         rsp_in.hit      = hit_ff;
      end else if (kind_ff == KIND_OVERLAP) begin
         rsp_in.hit      = hit_ff;
      end
   end

   assign stat.need_p1 = (kind_ff == KIND_MOVE) || (kind_ff == KIND_OVERLAP) ||
                         ((kind_ff == KIND_RESIZE) && grow_w);
   assign stat.need_p2 = (kind_ff == KIND_MOVE) ||
                         ((kind_ff == KIND_RESIZE) && grow_h);

   always_ff @(posedge clock) begin
      if (cmd.load && req_data.kind == KIND_ADD && count_ff < NW'(DEPTH))
         mem[count_ff[IW-1:0]] <= {req_data.coord_a, req_data.coord_b,
                                   req_data.coord_c, req_data.coord_d};
      if (cmd.rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         min_ff       <= SW'(1);
         max_ff       <= '1;
         ev_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ev_ff        <= cmd.rd_en;
         rsp_valid_ff <= cmd.finish;
         if (csr_we) begin
            unique case (csr_idx)
               CSR_MIN_SIZE: min_ff <= csr_wdata;
               CSR_MAX_SIZE: max_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) begin
            if (req_data.kind == KIND_CLEAR) count_ff <= '0;
            else if (req_data.kind == KIND_ADD && count_ff < NW'(DEPTH))
               count_ff <= count_ff + NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_data.kind;
         a_ff     <= sx(req_data.coord_a);
         b_ff     <= sx(req_data.coord_b);
         c_ff     <= sx(req_data.coord_c);
         d_ff     <= sx(req_data.coord_d);
         ta_ff    <= sx(req_data.target_a);
         tb_ff    <= sx(req_data.target_b);
         fx_ff    <= req_data.flip_x;
         fy_ff    <= req_data.flip_y;
         full_ff  <= (req_data.kind == KIND_ADD) && (count_ff >= NW'(DEPTH));
         hit_ff   <= 1'b0;
      end
      if (cmd.setup1) begin
         pass2_ff <= 1'b0;
         found_ff <= 1'b0;
         ux_ff    <= ta_ff;
         wv_ff    <= ta_ff;
         if (kind_ff == KIND_MOVE) begin
            sl_ff <= smin(a_ff, ta_ff);
            sr_ff <= smax(c_ff, ta_ff + w);
            st_ff <= b_ff;
            sb_ff <= b_ff + h;
         end else if (kind_ff == KIND_RESIZE) begin
            sl_ff <= fx_ff ? (a_ff - ta_ff) : a_ff;
            sr_ff <= fx_ff ? a_ff : (a_ff + ta_ff);
            st_ff <= fy_ff ? (b_ff - d_ff) : b_ff;
            sb_ff <= fy_ff ? b_ff : (b_ff + d_ff);
         end else begin
            sl_ff <= a_ff;
            st_ff <= b_ff;
            sr_ff <= c_ff;
            sb_ff <= d_ff;
         end
      end
      if (cmd.setup2) begin
         pass2_ff <= 1'b1;
         found_ff <= 1'b0;
         uy_ff    <= tb_ff;
         hv_ff    <= tb_ff;
         if (kind_ff == KIND_MOVE) begin
            sl_ff <= ux_ff;
            sr_ff <= ux_ff + w;
            st_ff <= smin(b_ff, tb_ff);
            sb_ff <= smax(d_ff, tb_ff + h);
         end else begin
            sl_ff <= left;
            sr_ff <= left + eff_w;
            st_ff <= fy_ff ? (b_ff - tb_ff) : b_ff;
            sb_ff <= fy_ff ? b_ff : (b_ff + tb_ff);
         end
      end
      if (ev_ff && ov) begin
         hit_ff <= 1'b1;
         if (kind_ff == KIND_MOVE) begin
            // strict less keeps the earliest of equally near edges
            if (!found_ff || gap < best_ff) begin
               found_ff <= 1'b1;
               best_ff  <= gap;
               if (pass2_ff) uy_ff <= cand;
               else          ux_ff <= cand;
            end
         end else if (kind_ff == KIND_RESIZE) begin
            if (pass2_ff) begin
               if (cand < hv_ff) hv_ff <= cand;
            end else begin
               if (cand < wv_ff) wv_ff <= cand;
            end
         end
      end
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   assign count     = count_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

@@ sv/swept_rect_collision_clamp.sv @@
// Top level of the swept rectangle collision clamp.
//  channel | ports                          | handshake
//  request | start, busy, req_data          | taken when start && !busy
//  result  | rsp_valid, rsp_data            | one-cycle strobe, no stall
//  config  | csr_we, csr_idx, csr_wdata     | written when csr_we
// One transaction at a time. Clear, add and unused kinds make no table
// pass. Each table pass reads every entry through the single memory read
// port: a move makes two passes, an overlap one, on a non-empty table.
// Synchronous reset empties the table count; entries are not cleared.
// The result is registered from the DONE state; the receiver cannot stall.
`default_nettype none
module swept_rect_collision_clamp #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire srcc_pkg::req_type       req_data,
   output logic                         rsp_valid,
   output srcc_pkg::rsp_type            rsp_data,
   input  wire logic                    csr_we,
   input  wire logic                    csr_idx,
   input  wire logic [srcc_pkg::SW-1:0] csr_wdata
);
   import srcc_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int NW = $clog2(TABLE_DEPTH + 1) + 1;

   cmd_type       cmd;
   stat_type      stat;
   logic [IW-1:0] rd_addr;
   logic [NW-1:0] count;
   logic          ctl_busy;

   srcc_ctrl #(.IW(IW), .NW(NW)) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start && !busy),
      .count   (count),
      .stat    (stat),
      .cmd     (cmd),
      .rd_addr (rd_addr),
      .busy    (ctl_busy)
   );

   srcc_dp #(.DEPTH(TABLE_DEPTH), .IW(IW), .NW(NW)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .count     (count),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // result strobe falls in the cycle after DONE, keep busy across it
   assign busy = ctl_busy || rsp_valid;
endmodule
`default_nettype wire

@@ sv/srcc_checker.sv @@
// Port-level checker for the collision clamp, bound to the top level.
`default_nettype none
module srcc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire srcc_pkg::rsp_type rsp_data
);
   import srcc_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accept did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than a cycle");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result shown while idle");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_full |->
         rsp_data.result_a == '0 && rsp_data.result_b == '0 && !rsp_data.hit)
      else $error("dropped add carries payload");

   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy held after result");
endmodule

bind swept_rect_collision_clamp srcc_checker u_srcc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire
